[rtl/mmpid_pkg.sv]
`default_nettype none

package mmpid_pkg;

    localparam int DEF_BUS_COUNT     = 2;
    localparam int DEF_SLOTS_PER_BUS = 11;

    // table index: bus is one bit, slot count and slot each fit 5 bits, so 6 bits suffice
    localparam int IDX_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = 48;
    localparam int SUM_W       = 50;

    localparam logic [1:0] KIND_FEEDBACK = 2'd0;
    localparam logic [1:0] KIND_SPEED    = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;

    localparam logic [2:0] MTYPE_1 = 3'd1;
    localparam logic [2:0] MTYPE_2 = 3'd2;
    localparam logic [2:0] MTYPE_3 = 3'd3;
    localparam logic [2:0] MTYPE_4 = 3'd4;

    localparam logic signed [SUM_W-1:0] LIM_16K     = SUM_W'(16384);
    localparam logic signed [SUM_W-1:0] LIM_25K     = SUM_W'(25000);
    localparam logic signed [SUM_W-1:0] NEG_LIM_16K = -LIM_16K;
    localparam logic signed [SUM_W-1:0] NEG_LIM_25K = -LIM_25K;

    typedef enum logic [1:0] {
        CLAMP_16K,
        CLAMP_25K,
        CLAMP_NONE
    } t_clamp;

    typedef enum logic [1:0] {
        MUL_P,
        MUL_I,
        MUL_D
    } t_mul_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic              bad;
        logic [3:0]        slot;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       pos;
        logic [15:0]       spd;
        logic [15:0]       target;
        logic [15:0]       kp;
        logic [15:0]       ki;
        logic [15:0]       kd;
        t_clamp            clamp;
    } t_item;

    typedef struct packed {
        logic     pop;
        logic     fb_we;
        logic     rd_en;
        logic     pid_we;
        logic     prod_en;
        t_mul_sel mul_sel;
        logic     acc_ld;
        logic     acc_add;
        logic     out_load;
    } t_ctrl;

endpackage

`default_nettype wire

[rtl/mmpid_front.sv]
`default_nettype none

module mmpid_front #(
    parameter int BUS_COUNT     = mmpid_pkg::DEF_BUS_COUNT,
    parameter int SLOTS_PER_BUS = mmpid_pkg::DEF_SLOTS_PER_BUS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_kind,
    input  wire logic                 i_bus,
    input  wire logic [3:0]           i_frame_slot,
    input  wire logic [63:0]          i_frame_data,
    input  wire logic [2:0]           i_motor_type,
    input  wire logic [3:0]           i_motor_number,
    input  wire logic [15:0]          i_target,
    input  wire logic [15:0]          i_proportional_gain,
    input  wire logic [15:0]          i_integral_gain,
    input  wire logic [15:0]          i_derivative_gain,
    output mmpid_pkg::t_item          o_head,
    output logic                      o_head_valid,
    input  wire logic                 i_pop
);
    import mmpid_pkg::*;

    localparam logic [2:0] BUS_LIM  = 3'(BUS_COUNT);
    localparam logic [4:0] SLOT_LIM = 5'(SLOTS_PER_BUS);

    logic              type34;
    logic [4:0]        pid_slot;
    logic              slot_neg;
    logic              bus_ok;
    logic              pid_bad;
    logic              keep;
    logic              push;
    logic [4:0]        use_slot;
    t_item             item;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    // classify
    always_comb begin
        type34   = (i_motor_type == MTYPE_3) || (i_motor_type == MTYPE_4);
        pid_slot = type34 ? ({1'b0, i_motor_number} + 5'd3) : ({1'b0, i_motor_number} - 5'd1);
        slot_neg = !type34 && (i_motor_number == 4'd0);
        bus_ok   = {2'b00, i_bus} < BUS_LIM;
        pid_bad  = !bus_ok || slot_neg || (pid_slot >= SLOT_LIM);
        use_slot = (i_kind == KIND_FEEDBACK) ? {1'b0, i_frame_slot} : pid_slot;
        unique case (i_kind)
            KIND_FEEDBACK: keep = bus_ok && ({1'b0, i_frame_slot} < SLOT_LIM);
            KIND_SPEED:    keep = 1'b1;
            KIND_POSITION: keep = 1'b1;
            default:       keep = 1'b0;
        endcase

        item.kind   = i_kind;
        item.bad    = pid_bad;
        item.slot   = pid_slot[3:0];
        item.idx    = i_bus ? ({1'b0, SLOT_LIM} + {1'b0, use_slot}) : {1'b0, use_slot};
        item.pos    = i_frame_data[63:48];
        item.spd    = i_frame_data[47:32];
        item.target = i_target;
        item.kp     = i_proportional_gain;
        item.ki     = i_integral_gain;
        item.kd     = i_derivative_gain;
        unique case (i_motor_type)
            MTYPE_1, MTYPE_2, MTYPE_4: item.clamp = CLAMP_16K;
            MTYPE_3:                   item.clamp = CLAMP_25K;
            default:                   item.clamp = CLAMP_NONE;
        endcase
    end

    // queue
    assign o_ready      = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push         = i_valid && o_ready && keep;
    assign o_head       = r_q[r_rptr];
    assign o_head_valid = (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= item;
        end
    end

endmodule

`default_nettype wire

[rtl/mmpid_back.sv]
`default_nettype none

module mmpid_back #(
    parameter int BUS_COUNT     = mmpid_pkg::DEF_BUS_COUNT,
    parameter int SLOTS_PER_BUS = mmpid_pkg::DEF_SLOTS_PER_BUS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mmpid_pkg::t_item     i_head,
    input  wire logic                 i_head_valid,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [31:0]               o_control_value,
    output logic [3:0]                o_slot_used,
    output logic                      o_index_error
);
    import mmpid_pkg::*;

    localparam int DEPTH = BUS_COUNT * SLOTS_PER_BUS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;
    t_item  r_item;

    logic [15:0] mem_pos  [DEPTH];
    logic [15:0] mem_spd  [DEPTH];
    logic [31:0] mem_int  [DEPTH];
    logic [15:0] mem_last [DEPTH];
    logic [DEPTH-1:0] r_fb_vld;
    logic [DEPTH-1:0] r_pid_vld;

    logic [15:0] r_rd_pos;
    logic [15:0] r_rd_spd;
    logic [31:0] r_rd_int;
    logic [15:0] r_rd_last;
    logic        r_rd_fb_vld;
    logic        r_rd_pid_vld;

    logic [AW-1:0] head_addr;
    logic [AW-1:0] item_addr;

    logic        is_spd;
    logic [15:0] pos_v;
    logic [15:0] spd_v;
    logic [31:0] int_v;
    logic [15:0] last_v;
    logic [16:0] meas17;
    logic [16:0] last17;
    logic [17:0] err18;
    logic [31:0] integ32;
    logic [17:0] deriv18;

    logic signed [17:0] r_err;
    logic signed [31:0] r_integ;
    logic signed [17:0] r_deriv;

    logic signed [15:0]       gain;
    logic signed [31:0]       oper;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  r_acc;

    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [3:0]  r_out_slot;
    logic        r_out_err;

    function automatic logic [31:0] clamp_sum(input logic signed [SUM_W-1:0] v,
                                              input t_clamp c);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic [31:0]             res;
        hi = (c == CLAMP_25K) ? LIM_25K : LIM_16K;
        lo = (c == CLAMP_25K) ? NEG_LIM_25K : NEG_LIM_16K;
        if (c == CLAMP_NONE) begin
            res = v[31:0];
        end else if (v > hi) begin
            res = hi[31:0];
        end else if (v < lo) begin
            res = lo[31:0];
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign head_addr = i_head.idx[AW-1:0];
    assign item_addr = r_item.idx[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.kind == KIND_FEEDBACK) begin
                        n_state = S_IDLE;
                    end else if (i_head.bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: n_state = S_MUL0;
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_SUM;
            S_SUM:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl          = '0;
        ctrl.mul_sel  = MUL_D;
        unique case (r_state)
            S_IDLE: begin
                ctrl.pop   = i_head_valid;
                ctrl.fb_we = i_head_valid && (i_head.kind == KIND_FEEDBACK);
                ctrl.rd_en = i_head_valid && (i_head.kind != KIND_FEEDBACK) && !i_head.bad;
            end
            S_LOAD: ctrl.pid_we = 1'b1;
            S_MUL0: begin
                ctrl.prod_en = 1'b1;
                ctrl.mul_sel = MUL_P;
            end
            S_MUL1: begin
                ctrl.prod_en = 1'b1;
                ctrl.mul_sel = MUL_I;
                ctrl.acc_ld  = 1'b1;
            end
            S_MUL2: begin
                ctrl.prod_en = 1'b1;
                ctrl.mul_sel = MUL_D;
                ctrl.acc_add = 1'b1;
            end
            S_SUM:  ctrl.acc_add = 1'b1;
            S_DONE: ctrl.out_load = !r_out_valid || i_ready;
            default: ctrl = '0;
        endcase
    end

    assign o_pop = ctrl.pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fb_vld    <= '0;
            r_pid_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctrl.fb_we) begin
                r_fb_vld[head_addr] <= 1'b1;
            end
            if (ctrl.pid_we) begin
                r_pid_vld[item_addr] <= 1'b1;
            end
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state memories
    always_ff @(posedge i_clk) begin
        if (ctrl.fb_we) begin
            mem_pos[head_addr] <= i_head.pos;
            mem_spd[head_addr] <= i_head.spd;
        end
        if (ctrl.rd_en) begin
            r_rd_pos     <= mem_pos[head_addr];
            r_rd_spd     <= mem_spd[head_addr];
            r_rd_fb_vld  <= r_fb_vld[head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.pid_we) begin
            mem_int[item_addr]  <= integ32;
            mem_last[item_addr] <= meas17[15:0];
        end
        if (ctrl.rd_en) begin
            r_rd_int     <= mem_int[head_addr];
            r_rd_last    <= mem_last[head_addr];
            r_rd_pid_vld <= r_pid_vld[head_addr];
        end
    end

    // error, integral and derivative
    always_comb begin
        is_spd  = (r_item.kind == KIND_SPEED);
        pos_v   = r_rd_fb_vld  ? r_rd_pos  : 16'd0;
        spd_v   = r_rd_fb_vld  ? r_rd_spd  : 16'd0;
        int_v   = r_rd_pid_vld ? r_rd_int  : 32'd0;
        last_v  = r_rd_pid_vld ? r_rd_last : 16'd0;
        meas17  = is_spd ? {spd_v[15], spd_v} : {1'b0, pos_v};
        last17  = is_spd ? {last_v[15], last_v} : {1'b0, last_v};
        err18   = {{2{r_item.target[15]}}, r_item.target} - {meas17[16], meas17};
        integ32 = int_v + {{14{err18[17]}}, err18};
        deriv18 = {last17[16], last17} - {meas17[16], meas17};
    end

    // shared multiplier
    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_P: begin
                gain = r_item.kp;
                oper = {{14{r_err[17]}}, r_err};
            end
            MUL_I: begin
                gain = r_item.ki;
                oper = r_integ;
            end
            default: begin
                gain = r_item.kd;
                oper = {{14{r_deriv[17]}}, r_deriv};
            end
        endcase
        prod_c   = gain * oper;
        prod_ext = {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.pop) begin
            r_item <= i_head;
        end
        if (ctrl.pid_we) begin
            r_err   <= err18;
            r_integ <= integ32;
            r_deriv <= deriv18;
        end
        if (ctrl.prod_en) begin
            r_prod <= prod_c;
        end
        if (ctrl.acc_ld) begin
            r_acc <= prod_ext;
        end else if (ctrl.acc_add) begin
            r_acc <= r_acc + prod_ext;
        end
        if (ctrl.out_load) begin
            r_out_value <= r_item.bad ? 32'd0 : clamp_sum(r_acc, r_item.clamp);
            r_out_slot  <= r_item.slot;
            r_out_err   <= r_item.bad;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_control_value = r_out_value;
    assign o_slot_used     = r_out_slot;
    assign o_index_error   = r_out_err;

`ifndef ASSERT_OFF
    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == 32'd0))
        else $error("index error word carries a nonzero drive value");

    a_clamp_16k : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.out_load && !r_item.bad && (r_item.clamp == CLAMP_16K)) |=>
        (($signed(r_out_value) <= 32'sd16384) && ($signed(r_out_value) >= -32'sd16384)))
        else $error("drive value escaped the 16384 clamp");

    a_out_from_load : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(ctrl.out_load))
        else $error("result word appeared without a load");

    a_pid_write_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.pid_we |-> (!r_item.bad && (r_item.kind != KIND_FEEDBACK)))
        else $error("PID state written for a flagged or feedback item");
`endif

endmodule

`default_nettype wire

[rtl/multi_motor_pid_regulator.sv]
// Multi-motor PID regulator: feedback and PID state for BUS_COUNT buses of
// SLOTS_PER_BUS motor slots.
// Input channel (i_valid / o_ready) takes one word per accepted edge: a
// feedback frame (kind 0) stores rotor position and speed into its slot, a
// speed (kind 1) or position (kind 2) step runs one PID update on the slot
// picked from motor type and number. Feedback frames to a slot outside the
// table and kind 3 words are dropped without a result.
// Output channel (o_valid / i_ready) gives one word per PID step: the drive
// value, clamped for motor types 1 to 4, the slot used and the index error
// flag. A front stage classifies words into a two-entry queue; the back
// stage executes them one at a time. A feedback frame is handled in the back
// stage's idle state and a flagged step goes straight to its output state; a
// PID step runs read, update, three products on one shared 16x32 multiplier,
// final sum and output load. Reset clears the queue, the back stage and the
// per-slot valid bits, so all tables read as zero. When the receiver stalls,
// the result holds, the back stage waits in its output state and the queue
// keeps accepting until full.
`default_nettype none

module multi_motor_pid_regulator #(
    parameter int BUS_COUNT     = mmpid_pkg::DEF_BUS_COUNT,
    parameter int SLOTS_PER_BUS = mmpid_pkg::DEF_SLOTS_PER_BUS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_bus,
    input  wire logic [3:0]  i_frame_slot,
    input  wire logic [63:0] i_frame_data,
    input  wire logic [2:0]  i_motor_type,
    input  wire logic [3:0]  i_motor_number,
    input  wire logic [15:0] i_target,
    input  wire logic [15:0] i_proportional_gain,
    input  wire logic [15:0] i_integral_gain,
    input  wire logic [15:0] i_derivative_gain,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_control_value,
    output logic [3:0]       o_slot_used,
    output logic             o_index_error
);
    import mmpid_pkg::*;

    // queue head between front and back
    t_item head;
    logic  head_valid;
    logic  pop;

    // classify and queue; drop words that leave no trace
    mmpid_front #(
        .BUS_COUNT     (BUS_COUNT),
        .SLOTS_PER_BUS (SLOTS_PER_BUS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_kind              (i_kind),
        .i_bus               (i_bus),
        .i_frame_slot        (i_frame_slot),
        .i_frame_data        (i_frame_data),
        .i_motor_type        (i_motor_type),
        .i_motor_number      (i_motor_number),
        .i_target            (i_target),
        .i_proportional_gain (i_proportional_gain),
        .i_integral_gain     (i_integral_gain),
        .i_derivative_gain   (i_derivative_gain),
        .o_head              (head),
        .o_head_valid        (head_valid),
        .i_pop               (pop)
    );

    // state tables, PID datapath and output register
    mmpid_back #(
        .BUS_COUNT     (BUS_COUNT),
        .SLOTS_PER_BUS (SLOTS_PER_BUS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_control_value (o_control_value),
        .o_slot_used     (o_slot_used),
        .o_index_error   (o_index_error)
    );

endmodule

`default_nettype wire
